### rtl/lkd_pkg.sv
// Shared types, codes and the jump-ahead coefficient table of the keystream decryptor.
package lkd_pkg;

  // Width of the key word and of every 32-bit register and field.
  localparam int unsigned WordBits = 32;
  // Width of the reported position.
  localparam int unsigned PosBits = 32;
  // Largest number of jump-ahead steps the coefficient table covers.
  localparam int unsigned MaxJumpSteps = 30;
  // Index width of the coefficient table.
  localparam int unsigned JumpIdxBits = 5;

  // One keystream step is key * KeyMul + KeyAdd.
  localparam logic [WordBits-1:0] KeyMul = 32'd7;
  localparam logic [WordBits-1:0] KeyAdd = 32'd3;

  // Operation codes carried in the op field; code three is unused.
  localparam logic [1:0] OpDecrypt = 2'd0;
  localparam logic [1:0] OpSeek    = 2'd1;
  localparam logic [1:0] OpOpen    = 2'd2;

  // Configuration register indexes.
  localparam logic CfgStartKey  = 1'b0;
  localparam logic CfgEntrySize = 1'b1;

  typedef struct packed {
    logic [1:0]          op;
    logic [7:0]          cipher_byte;
    logic [WordBits-1:0] seek_target;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]         plain_byte;
    logic               byte_valid;
    logic               seek_ok;
    logic [PosBits-1:0] position;
  } out_beat_t;

  // Composed step coefficients: applying entry i advances the key by 2**i dwords.
  typedef struct packed {
    logic [WordBits-1:0] m;
    logic [WordBits-1:0] a;
  } coef_t;

  typedef coef_t [MaxJumpSteps-1:0] coef_tab_t;

  // Squares the step once per entry: a' = a * (m + 1), m' = m * m.
  function automatic coef_tab_t jump_coefs();
    coef_tab_t           tab;
    logic [WordBits-1:0] m;
    logic [WordBits-1:0] a;
    m = KeyMul;
    a = KeyAdd;
    for (int i = 0; i < MaxJumpSteps; i++) begin
      tab[i].m = m;
      tab[i].a = a;
      a = a * (m + 32'd1);
      m = m * m;
    end
    return tab;
  endfunction

endpackage

### rtl/lcg_keystream_byte_decryptor.sv
// Top level of the keystream byte decryptor: sequencer, state registers and output stage.
//
// This block decrypts one archive entry a byte at a time. Each input beat carries an op:
// decrypt XORs the cipher byte with byte (offset mod 4) of the current key word and moves
// one byte on, stepping the key as key*7+3 whenever the offset reaches a dword boundary;
// seek moves to a target offset, rewinding to the start key first when moving backward and
// failing without change when the target lies at or past the entry end and is not the
// current offset; open returns to offset zero with the start key. Every input beat yields
// exactly one output beat that reports the decrypted byte, whether it was inside the entry,
// whether a seek or open succeeded, and the offset afterward. Decrypt, open, a zero-distance
// seek, a failed seek and a seek within the same dword load their result into the output
// register as they are accepted, and the next beat can be taken as soon as that register has
// room. A seek that crosses dword boundaries walks the bits of the dword count through the
// single shared multiply-add unit, one bit per cycle, stopping after the highest set bit
// or after JUMP_STEPS bits, and then hands over its result. The input side is not ready
// while a seek is walking or handing over its result, and it also waits while the output
// register holds a beat that has not been taken. Configuration writes to the start key and
// entry size take effect on the next beat that reads them; a new start key is used only at
// the next open or backward seek.
module lcg_keystream_byte_decryptor import lkd_pkg::*; #(
  parameter int unsigned JUMP_STEPS  = 30,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [WordBits-1:0] cfg_data_i,
  // Input beats.
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_beat_t            in_data_i,
  // Output beats.
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_beat_t           out_data_o
);

  // Dword count width, and the width of the counter that walks the coefficient table.
  localparam int unsigned DwBits   = OFFSET_BITS - 2;
  localparam int unsigned StepBits = (JUMP_STEPS > 1) ? $clog2(JUMP_STEPS) : 1;
  localparam logic [StepBits-1:0] LastStep = StepBits'(JUMP_STEPS - 1);
  localparam coef_tab_t CoefTab = jump_coefs();

  // One-hot sequencer states: waiting for a beat, walking a jump, handing over a seek result.
  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StJump = 3'b010,
    StDone = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  logic [WordBits-1:0]    start_key_q;
  logic [WordBits-1:0]    entry_size_q;
  logic [WordBits-1:0]    key_q, key_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic [DwBits-1:0]      dw_q, dw_d;
  logic [StepBits-1:0]    step_q, step_d;
  logic                   out_valid_q, out_valid_d;
  out_beat_t              out_data_q, out_data_d;

  logic                   in_fire;
  logic                   out_slot_free;
  logic                   out_load;
  logic [OFFSET_BITS-1:0] size;
  logic [OFFSET_BITS-1:0] target;
  logic [OFFSET_BITS-1:0] base_off;
  logic [DwBits-1:0]      dw_span;
  logic [WordBits-1:0]    mac_mul;
  logic [WordBits-1:0]    mac_add;
  logic [WordBits-1:0]    mac_res;
  coef_t                  coef;

  assign size   = entry_size_q[OFFSET_BITS-1:0];
  assign target = in_data_i.seek_target[OFFSET_BITS-1:0];

  // A backward seek restarts the walk from offset zero.
  assign base_off = (target < off_q) ? '0 : off_q;
  assign dw_span  = target[OFFSET_BITS-1:2] - base_off[OFFSET_BITS-1:2];

  assign out_slot_free = !out_valid_q || out_ready_i;
  assign in_ready_o    = (state_q == StIdle) && out_slot_free;
  assign in_fire       = in_valid_i && in_ready_o;

  // The multiply-add unit takes the single step while idle, and the composed coefficient
  // for the current bit of the dword count while a jump is walking.
  assign coef    = CoefTab[JumpIdxBits'(step_q)];
  assign mac_mul = (state_q == StJump) ? coef.m : KeyMul;
  assign mac_add = (state_q == StJump) ? coef.a : KeyAdd;

  lkd_mac u_mac (
    .key_i (key_q),
    .mul_i (mac_mul),
    .add_i (mac_add),
    .res_o (mac_res)
  );

  always_comb begin
    state_d    = state_q;
    key_d      = key_q;
    off_d      = off_q;
    dw_d       = dw_q;
    step_d     = step_q;
    out_load   = 1'b0;
    out_data_d = '0;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          out_load = 1'b1;
          unique case (in_data_i.op)
            OpDecrypt: begin
              // Past the entry end nothing is decrypted and nothing moves.
              if (off_q < size) begin
                out_data_d.plain_byte = in_data_i.cipher_byte ^
                                        8'(key_q >> {off_q[1:0], 3'b000});
                out_data_d.byte_valid = 1'b1;
                off_d = off_q + OFFSET_BITS'(1);
                if (off_d[1:0] == 2'b00) begin
                  key_d = mac_res;
                end
              end
            end
            OpSeek: begin
              if (target == off_q) begin
                out_data_d.seek_ok = 1'b1;
              end else if (target < size) begin
                off_d = target;
                key_d = (target < off_q) ? start_key_q : key_q;
                if (dw_span != '0) begin
                  // The result is produced once the jump has finished.
                  out_load = 1'b0;
                  dw_d     = dw_span;
                  step_d   = '0;
                  state_d  = StJump;
                end else begin
                  out_data_d.seek_ok = 1'b1;
                end
              end
            end
            OpOpen: begin
              off_d = '0;
              key_d = start_key_q;
              out_data_d.seek_ok = 1'b1;
            end
            default: begin
              // The unused op code only reports the position.
            end
          endcase
        end
      end
      StJump: begin
        if (dw_q[0]) begin
          key_d = mac_res;
        end
        dw_d   = dw_q >> 1;
        step_d = step_q + StepBits'(1);
        if (dw_d == '0 || step_q == LastStep) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_slot_free) begin
          out_load           = 1'b1;
          out_data_d.seek_ok = 1'b1;
          state_d            = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    out_data_d.position = PosBits'(off_d);
  end

  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      start_key_q  <= '0;
      entry_size_q <= '0;
      key_q        <= '0;
      off_q        <= '0;
      dw_q         <= '0;
      step_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      key_q       <= key_d;
      off_q       <= off_d;
      dw_q        <= dw_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgStartKey:  start_key_q  <= cfg_data_i;
          CfgEntrySize: entry_size_q <= cfg_data_i;
          default:      start_key_q  <= start_key_q;
        endcase
      end
    end
  end

  // The output payload register needs no reset; it is qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A beat is only taken while the sequencer is idle.
  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == StIdle))
    else $error("input ready outside the idle state");

  // The offset is settled when a jump starts and stays put while it walks.
  a_jump_keeps_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StJump) |=> $stable(off_q))
    else $error("offset moved during a jump");

  // A jump always ends in a successful seek result.
  a_jump_reports_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && out_load) |=> (out_valid_q && out_data_q.seek_ok))
    else $error("finished jump did not report success");

  // A decrypt past the entry end leaves the offset unchanged.
  a_no_move_past_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.op == OpDecrypt && off_q >= size) |=> $stable(off_q))
    else $error("offset moved on a decrypt past the entry end");

  // A decrypted byte always leaves the offset past zero.
  a_valid_byte_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.byte_valid) |-> (out_data_o.position != '0))
    else $error("valid byte reported at offset zero");

endmodule

### rtl/lkd_mac.sv
// Shared multiply-add unit that advances the key word: res = key * mul + add.
module lkd_mac import lkd_pkg::*; (
  input  logic [WordBits-1:0] key_i,
  input  logic [WordBits-1:0] mul_i,
  input  logic [WordBits-1:0] add_i,
  output logic [WordBits-1:0] res_o
);

  logic [WordBits-1:0] prod;

  // Only the low word of the product matters; the key arithmetic wraps modulo 2**32.
  assign prod  = key_i * mul_i;
  assign res_o = prod + add_i;

endmodule

### tb/lkd_decrypt_checker.sv
// Checker for the keystream byte decryptor: predicts every output beat and compares it.
module lkd_decrypt_checker import lkd_pkg::*; #(
  parameter int unsigned JUMP_STEPS  = 30,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [WordBits-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  in_beat_t            in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  out_beat_t           out_data_i,
  input  logic                done_i,
  output int                  pending_o,
  output int                  errors_o
);

  localparam logic [WordBits-1:0] OffMask = 32'hFFFF_FFFF >> (32 - OFFSET_BITS);

  logic [WordBits-1:0] start_key;
  logic [WordBits-1:0] entry_len;
  logic [WordBits-1:0] key_word;
  logic [WordBits-1:0] cursor;
  out_beat_t           plain_q[$];
  out_beat_t           want;
  int                  mismatches;

  // A pending result that never showed up counts once the stimulus is over.
  assign errors_o = mismatches + (done_i ? pending_o : 0);

  // Advances the key by the given number of dwords, squaring the step once per bit.
  function automatic logic [WordBits-1:0] leap_key(logic [WordBits-1:0] key,
                                                   logic [WordBits-1:0] dwords);
    logic [WordBits-1:0] m;
    logic [WordBits-1:0] a;
    m = KeyMul;
    a = KeyAdd;
    for (int i = 0; i < JUMP_STEPS; i++) begin
      if (dwords[i]) key = key * m + a;
      a = a * (m + 32'd1);
      m = m * m;
    end
    return key;
  endfunction

  // Applies one input beat to the cursor and key and returns the beat it must produce.
  function automatic out_beat_t decrypt_or_move(in_beat_t b);
    out_beat_t           r;
    logic [WordBits-1:0] tgt;
    logic [WordBits-1:0] lim;
    logic [WordBits-1:0] ks;
    r   = '0;
    tgt = b.seek_target & OffMask;
    lim = entry_len & OffMask;
    case (b.op)
      OpDecrypt: begin
        if (cursor < lim) begin
          ks           = key_word >> {cursor[1:0], 3'b000};
          r.plain_byte = b.cipher_byte ^ ks[7:0];
          r.byte_valid = 1'b1;
          cursor       = cursor + 32'd1;
          if (cursor[1:0] == 2'b00) key_word = key_word * KeyMul + KeyAdd;
        end
      end
      OpSeek: begin
        if (tgt == cursor) begin
          r.seek_ok = 1'b1;
        end else if (tgt < lim) begin
          if (tgt < cursor) begin
            cursor   = '0;
            key_word = start_key;
          end
          key_word  = leap_key(key_word, (tgt >> 2) - (cursor >> 2));
          cursor    = tgt;
          r.seek_ok = 1'b1;
        end
      end
      OpOpen: begin
        cursor    = '0;
        key_word  = start_key;
        r.seek_ok = 1'b1;
      end
      default: begin
      end
    endcase
    r.position = cursor;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_key  = '0;
      entry_len  = '0;
      key_word   = '0;
      cursor     = '0;
      mismatches = 0;
      pending_o  = 0;
      plain_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgStartKey:  start_key = cfg_data_i;
          CfgEntrySize: entry_len = cfg_data_i;
          default: begin
          end
        endcase
      end
      // Outputs are checked before new inputs are predicted, so a beat can never be
      // matched against a prediction made at the same edge.
      if (out_valid_i && out_ready_i) begin
        if (plain_q.size() == 0) begin
          if (mismatches < 10)
            $display("ERROR: unexpected output beat plain=%h valid=%b ok=%b pos=%h",
                     out_data_i.plain_byte, out_data_i.byte_valid, out_data_i.seek_ok,
                     out_data_i.position);
          mismatches++;
        end else begin
          want = plain_q.pop_front();
          if (out_data_i.plain_byte !== want.plain_byte ||
              out_data_i.byte_valid !== want.byte_valid ||
              out_data_i.seek_ok !== want.seek_ok ||
              out_data_i.position !== want.position) begin
            if (mismatches < 10)
              $display("ERROR: output mismatch: expected plain=%h valid=%b ok=%b pos=%h, %s",
                       want.plain_byte, want.byte_valid, want.seek_ok, want.position,
                       $sformatf("got plain=%h valid=%b ok=%b pos=%h",
                                 out_data_i.plain_byte, out_data_i.byte_valid,
                                 out_data_i.seek_ok, out_data_i.position));
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) plain_q.push_back(decrypt_or_move(in_data_i));
      pending_o = plain_q.size();
    end
  end

endmodule

### tb/tb_lcg_keystream_byte_decryptor.sv
// Testbench top for the keystream byte decryptor: clock, reset, stimulus and verdict.
module tb_lcg_keystream_byte_decryptor;
  import lkd_pkg::*;

  localparam int unsigned JumpSteps    = 30;
  localparam int unsigned OffsetBits   = 32;
  // The op code the block must ignore.
  localparam logic [1:0]  OpUnused     = 2'd3;
  // Long receiver hold-off used once to fill the block and stall its input.
  localparam int          HoldCycles   = 200;
  // Quiet cycles let after the last result before a register write or the verdict.
  localparam int          SettleCycles = 40;
  // Cycles without any accepted beat before the run is declared hung.
  localparam int          StallLimit   = 1000;
  localparam int          RandPhases   = 8;
  localparam int          PhaseBeats   = 50;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic                cfg_idx;
  logic [WordBits-1:0] cfg_data;
  logic                in_valid;
  logic                in_ready;
  in_beat_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_beat_t           out_data;
  logic                done;
  int                  pending;
  int                  errors;

  // The entry size currently programmed, so random seeks can aim inside the entry.
  logic [WordBits-1:0] entry_len;
  // Calm flags switch off idling on one side for a whole phase.
  bit                  send_calm;
  bit                  recv_calm;
  // Raised by the stimulus to make the receiver hold off once for a long stretch.
  bit                  hold_out;

  lcg_keystream_byte_decryptor #(
    .JUMP_STEPS (JumpSteps),
    .OFFSET_BITS(OffsetBits)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  lkd_decrypt_checker #(
    .JUMP_STEPS (JumpSteps),
    .OFFSET_BITS(OffsetBits)
  ) checker_i (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .done_i     (done),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Each side draws a random wait before every beat unless its phase is calm.
  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  // Offers one beat from a falling edge and returns at the falling edge after the
  // rising edge that accepted it. With no gap drawn, valid simply stays high into
  // the next beat, so it is never dropped and raised within one time step.
  task automatic send(logic [1:0] op, logic [7:0] cb, logic [WordBits-1:0] tgt);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = '{op: op, cipher_byte: cb, seek_target: tgt};
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Registers may only change while the block is idle: every predicted beat has
  // arrived, and a walking jump has had time to finish.
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [WordBits-1:0] value);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we   = 1'b0;
    if (idx == CfgEntrySize) entry_len = value;
  endtask

  // Mostly byte runs and seeks inside the entry, so decryption reaches deep offsets
  // and the jump walks many dword counts; the rest are opens, seeks at or past the
  // end or anywhere in the offset space, and the unused op.
  task automatic random_beat();
    int unsigned         pick;
    logic [WordBits-1:0] hi;
    logic [WordBits-1:0] tgt;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      send(OpDecrypt, 8'($urandom_range(0, 255)), $urandom);
    end else if (pick < 75) begin
      if (entry_len == 0) begin
        tgt = $urandom_range(0, 8);
      end else begin
        hi  = entry_len - 32'd1;
        tgt = $urandom_range(0, 1) ? $urandom_range(0, (hi < 80) ? hi : 80)
                                   : $urandom_range(0, hi);
      end
      send(OpSeek, 8'($urandom_range(0, 255)), tgt);
    end else if (pick < 85) begin
      send(OpOpen, 8'($urandom_range(0, 255)), $urandom);
    end else if (pick < 93) begin
      tgt = $urandom_range(0, 1) ? $urandom : entry_len + $urandom_range(0, 3);
      send(OpSeek, 8'($urandom_range(0, 255)), tgt);
    end else begin
      send(OpUnused, 8'($urandom_range(0, 255)), $urandom);
    end
  endtask

  function automatic logic [WordBits-1:0] pick_key();
    case ($urandom_range(0, 3))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [WordBits-1:0] pick_size();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return $urandom_range(2, 64);
      3:       return $urandom_range(65, 4096);
      4:       return $urandom;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Receiver: draws a wait for every beat, and once holds off for a long stretch
  // while the sender keeps offering, so the output register fills and input stalls.
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_out) begin
        out_ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_out = 1'b0;
      end
      gap = draw_gap(recv_calm);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Watchdog: a long run of cycles with no beat accepted on either channel means
  // the block has hung.
  initial begin
    int stall;
    stall = 0;
    wait (rst_n);
    while (stall < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall = 0;
      else stall++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = CfgStartKey;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    done      = 1'b0;
    entry_len = '0;
    send_calm = 1'b0;
    recv_calm = 1'b0;
    hold_out  = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // With the reset configuration the entry is empty: a decrypt yields no byte,
    // a seek to the current offset still succeeds, any other seek fails, the
    // unused op is ignored and open always succeeds.
    send(OpDecrypt, 8'hFF, 32'hFFFF_FFFF);
    send(OpSeek, 8'h00, 32'h0000_0000);
    send(OpSeek, 8'hA5, 32'h0000_0005);
    send(OpUnused, 8'hFF, 32'hFFFF_FFFF);
    send(OpOpen, 8'h00, 32'h0000_0000);
    settle();

    // Largest key and entry: stream across a dword boundary, jump to the far end
    // with every dword bit but the lowest set, fail a seek to the entry end, run off the end, then
    // seek to the current offset at the end and rewind backward.
    write_reg(CfgStartKey, 32'hFFFF_FFFF);
    write_reg(CfgEntrySize, 32'hFFFF_FFFF);
    send(OpOpen, 8'h00, 32'h0000_0000);
    send(OpDecrypt, 8'h00, 32'h0000_0000);
    send(OpDecrypt, 8'hFF, 32'hFFFF_FFFF);
    send(OpDecrypt, 8'h5A, 32'h0000_0000);
    send(OpDecrypt, 8'hA5, 32'hFFFF_FFFF);
    send(OpDecrypt, 8'h00, 32'h0000_0000);
    send(OpSeek, 8'h00, 32'hFFFF_FFFE);
    send(OpSeek, 8'h00, 32'hFFFF_FFFF);
    send(OpDecrypt, 8'hFF, 32'h0000_0000);
    send(OpDecrypt, 8'hFF, 32'h0000_0000);
    send(OpSeek, 8'h00, 32'hFFFF_FFFF);
    send(OpSeek, 8'h00, 32'h0000_0003);
    send(OpSeek, 8'h00, 32'h0000_0002);
    send(OpSeek, 8'h00, 32'h4000_0001);
    send(OpSeek, 8'h00, 32'h4000_0001);
    send(OpUnused, 8'h00, 32'h0000_0000);
    send(OpOpen, 8'hFF, 32'hFFFF_FFFF);
    send(OpSeek, 8'h00, 32'h0000_0008);
    settle();

    // Random phases, each with its own key and entry size; one phase also carries
    // the long receiver hold-off with the sender offering back to back.
    for (int ph = 0; ph < RandPhases; ph++) begin
      write_reg(CfgStartKey, pick_key());
      write_reg(CfgEntrySize, pick_size());
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);
      if (ph == 3) begin
        send_calm = 1'b1;
        hold_out  = 1'b1;
      end
      send(OpOpen, 8'($urandom_range(0, 255)), $urandom);
      for (int n = 0; n < PhaseBeats; n++) random_beat();
      settle();
    end

    done = 1'b1;
    @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
